// File: rtl/pip_pkg.sv
`timescale 1ns / 1ps

package pip_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VIDX_W       = 8;
  localparam int VC_W         = 9;
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int COUNT_W      = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic signed [COORD_W-1:0] RAY_END_Y_RESET = COORD_W'(819);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_END_Y    = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  function automatic diff_t sub_ext(input coord_t a, input coord_t b);
    diff_t ea;
    diff_t eb;
    ea = DIFF_W'(a);
    eb = DIFF_W'(b);
    return ea - eb;
  endfunction

  // True when the product of the two differences is strictly negative.
  function automatic logic prod_neg(input diff_t a, input diff_t b);
    return (a != '0) && (b != '0) && (a[DIFF_W-1] != b[DIFF_W-1]);
  endfunction

endpackage

// File: rtl/pip_in_if.sv
`timescale 1ns / 1ps

interface pip_in_if;
  import pip_pkg::*;

  logic                valid;
  logic                ready;
  logic                command;
  logic [VIDX_W-1:0]   vertex_index;
  logic [COORD_W-1:0]  coord_x;
  logic [COORD_W-1:0]  coord_y;

  modport source (output valid, command, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, command, vertex_index, coord_x, coord_y, output ready);
endinterface

// File: rtl/pip_out_if.sv
`timescale 1ns / 1ps

interface pip_out_if;
  import pip_pkg::*;

  logic                valid;
  logic                ready;
  logic                inside_res;
  logic [COUNT_W-1:0]  crossing_count;

  modport source (output valid, inside_res, crossing_count, input ready);
  modport sink   (input valid, inside_res, crossing_count, output ready);
endinterface

// File: rtl/pip_cfg_if.sv
`timescale 1ns / 1ps

interface pip_cfg_if;
  import pip_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/point_in_polygon_parity_test.sv
`timescale 1ns / 1ps

// Point-in-polygon parity test.
// Channels: in_i carries load and query items, out_o carries one result per
// query, cfg_i writes vertex_count (index 0) and ray_end_y (index 1); cfg_i
// is always ready. A load transfer writes one slot of the vertex memory in
// the cycle it is accepted and gives no result; the block stays ready.
// A query walks the outline one segment per cycle: the vertex memory is read
// at one address a cycle and the previous vertex is held in a register, then
// a two-stage segment unit forms and compares the cross products. A query
// for a point at the origin or with fewer than two vertices in use gives a
// result without a walk. The block takes no new item during a walk.
// The result sits in an output register; a stalled receiver holds it there,
// a following item may still be accepted, and a later query waits with its
// result until the register is free. Reset clears the control state and the
// configuration registers (vertex_count 0, ray_end_y 819); the vertex memory is not
// cleared and must be loaded before use.
module point_in_polygon_parity_test
  import pip_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pip_in_if.sink     in_i,
  pip_out_if.source  out_o,
  pip_cfg_if.sink    cfg_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [VC_W-1:0]    vc_q;
  coord_t             ray_q;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic               s1_v_q, s1_v_d;
  logic               s1_first_q, s1_first_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               inside_q, inside_d;
  logic               out_valid_q, out_valid_d;
  logic               out_inside_q;
  logic [COUNT_W-1:0] out_count_q;
  coord_t             px_q, py_q, qy_q;
  coord_t             prev_x_q, prev_y_q;

  logic                   in_accept;
  logic                   is_query;
  logic                   at_origin;
  logic                   ram_we;
  logic [2*COORD_W-1:0]   ram_rdata;
  coord_t                 cur_x, cur_y;
  logic                   seg_valid;
  logic                   seg_cross;
  logic                   walk_done;
  logic                   out_load;
  logic [CNT_W-1:0]       n_clamped;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign is_query   = (in_i.command == CMD_QUERY);
  assign at_origin  = (in_i.coord_x == '0) && (in_i.coord_y == '0);
  assign ram_we     = in_accept && (in_i.command == CMD_LOAD)
                      && (32'(in_i.vertex_index) < 32'(MAX_VERTICES));
  assign n_clamped  = (32'(vc_q) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                       : CNT_W'(vc_q);

  pip_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ADDR_W'(in_i.vertex_index)),
    .wdata_i ({in_i.coord_x, in_i.coord_y}),
    .raddr_i (rd_cnt_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign cur_x = ram_rdata[2*COORD_W-1:COORD_W];
  assign cur_y = ram_rdata[COORD_W-1:0];

  pip_seg u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_v_q && !s1_first_q),
    .px_i    (px_q),
    .py_i    (py_q),
    .qy_i    (qy_q),
    .sx_i    (prev_x_q),
    .sy_i    (prev_y_q),
    .tx_i    (cur_x),
    .ty_i    (cur_y),
    .valid_o (seg_valid),
    .cross_o (seg_cross)
  );

  assign walk_done = (rd_cnt_q == n_q) && !s1_v_q && !seg_valid;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    rd_cnt_d    = rd_cnt_q;
    s1_v_d      = 1'b0;
    s1_first_d  = s1_first_q;
    count_d     = count_q;
    inside_d    = inside_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (in_accept && is_query) begin
          n_d      = n_clamped;
          rd_cnt_d = '0;
          count_d  = '0;
          if (at_origin) begin
            inside_d = 1'b1;
            state_d  = ST_DONE;
          end else if (n_clamped < CNT_W'(2)) begin
            inside_d = 1'b0;
            state_d  = ST_DONE;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (rd_cnt_q < n_q) begin
          rd_cnt_d   = rd_cnt_q + CNT_W'(1);
          s1_v_d     = 1'b1;
          s1_first_d = (rd_cnt_q == '0);
        end
        if (seg_valid && seg_cross) begin
          count_d = count_q + COUNT_W'(1);
        end
        if (walk_done) begin
          inside_d = count_q[0];
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vc_q        <= '0;
      ray_q       <= RAY_END_Y_RESET;
      n_q         <= '0;
      rd_cnt_q    <= '0;
      s1_v_q      <= 1'b0;
      s1_first_q  <= 1'b0;
      count_q     <= '0;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      rd_cnt_q    <= rd_cnt_d;
      s1_v_q      <= s1_v_d;
      s1_first_q  <= s1_first_d;
      count_q     <= count_d;
      inside_q    <= inside_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_VERTEX_COUNT: vc_q  <= cfg_i.data[VC_W-1:0];
          REG_RAY_END_Y:    ray_q <= coord_t'(cfg_i.data[COORD_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && is_query) begin
      px_q <= coord_t'(in_i.coord_x);
      py_q <= coord_t'(in_i.coord_y);
      qy_q <= ray_q;
    end
    if (s1_v_q) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
    end
    if (out_load) begin
      out_inside_q <= inside_q;
      out_count_q  <= count_q;
    end
  end

  assign cfg_i.ready          = 1'b1;
  assign out_o.valid          = out_valid_q;
  assign out_o.inside_res     = out_inside_q;
  assign out_o.crossing_count = out_count_q;

  // The read counter never runs past the number of vertices in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (rd_cnt_q <= n_q))
    else $error("vertex read counter ran past the vertex count");

  // No more crossings than segments can ever be counted during a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (CNT_W'(count_q) < n_q))
    else $error("crossing count exceeds the number of segments");

  // The segment pipeline is empty whenever the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_v_q && !seg_valid))
    else $error("segment pipeline busy while idle");

  // A finished query always lands in the output register on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("result not delivered to the output register");

endmodule

// File: rtl/pip_ram.sv
`timescale 1ns / 1ps

module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/pip_seg.sv
`timescale 1ns / 1ps

// Two-stage crossing test of one outline segment S-T against the vertical
// probe from P = (px, py) to Q = (px, qy). The first stage forms the
// differences and the four cross products, the second compares them.
module pip_seg
  import pip_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  coord_t px_i,
  input  coord_t py_i,
  input  coord_t qy_i,
  input  coord_t sx_i,
  input  coord_t sy_i,
  input  coord_t tx_i,
  input  coord_t ty_i,
  output logic   valid_o,
  output logic   cross_o
);

  diff_t ax;
  diff_t bx;
  diff_t dpt;
  diff_t dps;
  diff_t dqt;
  diff_t dqs;
  diff_t dq;

  prod_t p1_q, p2_q, p3_q, p4_q;
  logic  o3_q, o4_q;
  logic  valid_q;

  assign ax  = sub_ext(sx_i, px_i);
  assign bx  = sub_ext(tx_i, px_i);
  assign dpt = sub_ext(ty_i, py_i);
  assign dps = sub_ext(sy_i, py_i);
  assign dqt = sub_ext(ty_i, qy_i);
  assign dqs = sub_ext(sy_i, qy_i);
  assign dq  = sub_ext(qy_i, py_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      p1_q <= prod_t'(dpt) * prod_t'(ax);
      p2_q <= prod_t'(dps) * prod_t'(bx);
      p3_q <= prod_t'(dqt) * prod_t'(ax);
      p4_q <= prod_t'(dqs) * prod_t'(bx);
      // With P and Q on one vertical line, the orientation of P, Q and a
      // vertex reduces to the sign of one product.
      o3_q <= prod_neg(dq, ax);
      o4_q <= prod_neg(dq, bx);
    end
  end

  assign valid_o = valid_q;
  assign cross_o = ((p1_q > p2_q) != (p3_q > p4_q)) && (o3_q != o4_q);

endmodule
